// ----- rtl/core/bnpm_pkg.sv -----
// Shared constants, types and the bracket decoder of the pair matcher.
// No dependencies.
package bnpm_pkg;

	localparam int MAX_LEN       = 1024;
	localparam int BRACKET_KINDS = 8;

	localparam int KIND_W  = 3;
	localparam int LEN_W   = $clog2(MAX_LEN);
	localparam int DEPTH_W = LEN_W + 1;
	localparam int ADDR_W  = KIND_W + LEN_W;
	localparam int MEM_DEPTH = BRACKET_KINDS * MAX_LEN;

	localparam int SYM_W   = 8;
	localparam int POS_W   = 10;
	localparam int LENF_W  = 11;
	localparam int TDATA_W = 40;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNMATCHED = 2'd1,
		ST_UNCLOSED  = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	typedef enum logic {
		REC_PAIR = 1'b0,
		REC_END  = 1'b1
	} rec_kind_t;

	typedef struct packed {
		logic              is_open;
		logic              is_close;
		logic [KIND_W-1:0] kind;
	} sym_class_t;

	function automatic sym_class_t classify(input logic [SYM_W-1:0] sym);
		sym_class_t c;
		c = '{is_open: 1'b0, is_close: 1'b0, kind: '0};
		unique case (sym)
			"(": c = '{1'b1, 1'b0, 3'd0};
			"<": c = '{1'b1, 1'b0, 3'd1};
			"[": c = '{1'b1, 1'b0, 3'd2};
			"{": c = '{1'b1, 1'b0, 3'd3};
			"A": c = '{1'b1, 1'b0, 3'd4};
			"B": c = '{1'b1, 1'b0, 3'd5};
			"C": c = '{1'b1, 1'b0, 3'd6};
			"D": c = '{1'b1, 1'b0, 3'd7};
			")": c = '{1'b0, 1'b1, 3'd0};
			">": c = '{1'b0, 1'b1, 3'd1};
			"]": c = '{1'b0, 1'b1, 3'd2};
			"}": c = '{1'b0, 1'b1, 3'd3};
			"a": c = '{1'b0, 1'b1, 3'd4};
			"b": c = '{1'b0, 1'b1, 3'd5};
			"c": c = '{1'b0, 1'b1, 3'd6};
			"d": c = '{1'b0, 1'b1, 3'd7};
			default: c = '{1'b0, 1'b0, 3'd0};
		endcase
		if (32'(c.kind) >= BRACKET_KINDS) begin
			c.is_open  = 1'b0;
			c.is_close = 1'b0;
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/bracket_notation_pair_matcher.sv -----
// Bracket-notation pair matcher: per-kind stacks of open positions in one RAM.
// A pair or end record passes the s1 registers and then the output register to m_tdata.
// Takes one character per cycle unless m_tready stalls; pair plus end holds off the next.
// Stack RAM has a registered read; push and pop never share an entry in the same cycle.
// Reset clears position, depths, status and pipeline valids; RAM contents are not cleared.
// Depends on bnpm_pkg.
module bracket_notation_pair_matcher
	import bnpm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,   // [7:0] symbol
	input  logic               s_tlast,   // last
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,   // open_pos, close_pos, length, status, zero pad
	output logic               m_tuser,   // kind
	output logic               m_tlast    // final_res
);

	logic [POS_W-1:0] stack_mem [MEM_DEPTH];

	logic [DEPTH_W-1:0] depth_q [BRACKET_KINDS];
	logic [DEPTH_W-1:0] depth_nxt [BRACKET_KINDS];
	logic [LENF_W-1:0]  pos_q;
	status_t            err_q;

	logic               pair_pend_s1, end_pend_s1;
	logic [POS_W-1:0]   open_s1, close_s1;
	logic [LENF_W-1:0]  len_s1;
	status_t            stat_s1;

	logic               out_valid_q;
	rec_kind_t          out_kind_q;
	logic [POS_W-1:0]   out_open_q, out_close_q;
	logic [LENF_W-1:0]  out_len_q;
	status_t            out_stat_q;

	logic               accept, out_free, overflow, any_open;
	sym_class_t         cls;
	logic [DEPTH_W-1:0] d_cur;
	logic               do_push, do_pop, pop_empty;
	logic [ADDR_W-1:0]  waddr, raddr;
	logic [LENF_W-1:0]  pos_nxt;
	status_t            err_nxt, stat_end;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (!pair_pend_s1 && !end_pend_s1) ||
	                  (out_free && (pair_pend_s1 ^ end_pend_s1));
	assign accept   = s_tvalid && s_tready;

	assign overflow  = (pos_q == LENF_W'(MAX_LEN));
	assign cls       = classify(s_tdata);
	assign d_cur     = depth_q[cls.kind];
	assign do_push   = !overflow && cls.is_open && (d_cur < DEPTH_W'(MAX_LEN));
	assign pop_empty = (d_cur == '0);
	assign do_pop    = !overflow && cls.is_close && !pop_empty;
	assign waddr     = {cls.kind, d_cur[LEN_W-1:0]};
	assign raddr     = {cls.kind, LEN_W'(d_cur - DEPTH_W'(1))};

	always_comb begin
		for (int k = 0; k < BRACKET_KINDS; k++) begin
			depth_nxt[k] = depth_q[k];
		end
		if (do_push) begin
			depth_nxt[cls.kind] = d_cur + DEPTH_W'(1);
		end else if (do_pop) begin
			depth_nxt[cls.kind] = d_cur - DEPTH_W'(1);
		end
		any_open = 1'b0;
		for (int k = 0; k < BRACKET_KINDS; k++) begin
			any_open = any_open | (depth_nxt[k] != '0);
		end
		pos_nxt = overflow ? pos_q : pos_q + LENF_W'(1);
		err_nxt = err_q;
		if (overflow) begin
			err_nxt = ST_OVERFLOW;
		end else if (cls.is_close && pop_empty && err_q != ST_OVERFLOW) begin
			err_nxt = ST_UNMATCHED;
		end
		stat_end = (err_nxt == ST_OK && any_open) ? ST_UNCLOSED : err_nxt;
	end

	always_ff @(posedge clk) begin
		if (accept && do_push) begin
			stack_mem[waddr] <= pos_q[POS_W-1:0];
		end
		if (accept) begin
			open_s1 <= stack_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < BRACKET_KINDS; k++) begin
				depth_q[k] <= '0;
			end
			pos_q <= '0;
			err_q <= ST_OK;
		end else if (accept) begin
			if (s_tlast) begin
				for (int k = 0; k < BRACKET_KINDS; k++) begin
					depth_q[k] <= '0;
				end
				pos_q <= '0;
				err_q <= ST_OK;
			end else begin
				for (int k = 0; k < BRACKET_KINDS; k++) begin
					depth_q[k] <= depth_nxt[k];
				end
				pos_q <= pos_nxt;
				err_q <= err_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_pend_s1 <= 1'b0;
			end_pend_s1  <= 1'b0;
		end else begin
			if (out_free && pair_pend_s1) begin
				pair_pend_s1 <= 1'b0;
			end else if (out_free && end_pend_s1) begin
				end_pend_s1 <= 1'b0;
			end
			if (accept) begin
				pair_pend_s1 <= do_pop;
				end_pend_s1  <= s_tlast;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			close_s1 <= pos_q[POS_W-1:0];
			len_s1   <= pos_nxt;
			stat_s1  <= stat_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pair_pend_s1 || end_pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pair_pend_s1) begin
				out_kind_q  <= REC_PAIR;
				out_open_q  <= open_s1;
				out_close_q <= close_s1;
				out_len_q   <= '0;
				out_stat_q  <= ST_OK;
			end else begin
				out_kind_q  <= REC_END;
				out_open_q  <= '0;
				out_close_q <= '0;
				out_len_q   <= len_s1;
				out_stat_q  <= stat_s1;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_stat_q, out_len_q, out_close_q, out_open_q};
	assign m_tuser  = out_kind_q;
	assign m_tlast  = (out_kind_q == REC_END);

endmodule

// ----- tb/bracket_notation_pair_matcher_checker.sv -----
`timescale 1ns / 1ps
// Stream checker for the bracket pair matcher: predicts pair and end records from taken
// characters and compares them with records taken on the master side. Depends on bnpm_pkg.
module bracket_notation_pair_matcher_checker
	import bnpm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tready,
	input  logic [7:0]         s_tdata,
	input  logic               s_tlast,
	input  logic               m_tvalid,
	input  logic               m_tready,
	input  logic [TDATA_W-1:0] m_tdata,
	input  logic               m_tuser,
	input  logic               m_tlast,
	output int                 errors,
	output int                 pending,
	output int                 pairs_seen
);

	localparam logic [63:0] OPEN_SET  = "(<[{ABCD";
	localparam logic [63:0] CLOSE_SET = ")>]}abcd";
	localparam int          MAX_SHOWN = 50;

	typedef struct packed {
		rec_kind_t         kind;
		logic              fin;
		logic [6:0]        pad;
		status_t           status;
		logic [LENF_W-1:0] length;
		logic [POS_W-1:0]  close_pos;
		logic [POS_W-1:0]  open_pos;
	} match_rec_t;

	match_rec_t       expected_recs[$];
	logic [POS_W-1:0] open_positions [BRACKET_KINDS*MAX_LEN];
	int               depth [BRACKET_KINDS];
	int               cur_pos = 0;
	status_t          cur_status = ST_OK;
	int               err_cnt = 0;
	int               n_pending = 0;
	int               n_pairs = 0;

	assign errors     = err_cnt;
	assign pending    = n_pending;
	assign pairs_seen = n_pairs;

	initial begin
		for (int k = 0; k < BRACKET_KINDS; k++)
			depth[k] = 0;
	end

	task automatic predict_records(input logic [7:0] sym, input logic last);
		match_rec_t r;
		bit         is_open;
		bit         is_close;
		int         kk;
		int         k;
		is_open  = 1'b0;
		is_close = 1'b0;
		kk       = 0;
		if (cur_pos >= MAX_LEN) begin
			cur_pos    = MAX_LEN;
			cur_status = ST_OVERFLOW;
		end else begin
			for (k = 0; k < BRACKET_KINDS; k++) begin
				if (sym == OPEN_SET[8*(7-k) +: 8]) begin
					is_open = 1'b1;
					kk      = k;
				end
				if (sym == CLOSE_SET[8*(7-k) +: 8]) begin
					is_close = 1'b1;
					kk       = k;
				end
			end
			if (is_open) begin
				if (depth[kk] < MAX_LEN) begin
					open_positions[kk*MAX_LEN + depth[kk]] = POS_W'(cur_pos);
					depth[kk]++;
				end
			end else if (is_close) begin
				if (depth[kk] == 0) begin
					if (cur_status != ST_OVERFLOW)
						cur_status = ST_UNMATCHED;
				end else begin
					depth[kk]--;
					r           = '0;
					r.kind      = REC_PAIR;
					r.open_pos  = open_positions[kk*MAX_LEN + depth[kk]];
					r.close_pos = POS_W'(cur_pos);
					expected_recs = {expected_recs, r};
				end
			end
			cur_pos++;
		end
		if (last) begin
			if (cur_status == ST_OK) begin
				for (k = 0; k < BRACKET_KINDS; k++)
					if (depth[k] != 0)
						cur_status = ST_UNCLOSED;
			end
			r        = '0;
			r.kind   = REC_END;
			r.fin    = 1'b1;
			r.length = LENF_W'(cur_pos);
			r.status = cur_status;
			expected_recs = {expected_recs, r};
			for (k = 0; k < BRACKET_KINDS; k++)
				depth[k] = 0;
			cur_pos    = 0;
			cur_status = ST_OK;
		end
	endtask

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			err_cnt++;
			if (err_cnt <= MAX_SHOWN)
				$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_record();
		match_rec_t want;
		match_rec_t got;
		// m_tdata: [9:0] open_pos, [19:10] close_pos, [30:20] length, [32:31] status
		got.open_pos  = m_tdata[9:0];
		got.close_pos = m_tdata[19:10];
		got.length    = m_tdata[30:20];
		got.status    = status_t'(m_tdata[32:31]);
		got.pad       = m_tdata[39:33];
		got.kind      = rec_kind_t'(m_tuser);
		got.fin       = m_tlast;
		if (expected_recs.size() == 0) begin
			err_cnt++;
			if (err_cnt <= MAX_SHOWN)
				$display("%0t ns: unexpected record, expected none, actual tdata=%h tuser=%b tlast=%b",
					$time, m_tdata, m_tuser, m_tlast);
		end else begin
			want = expected_recs.pop_front();
			compare_field("kind", want.kind, got.kind);
			compare_field("open_pos", want.open_pos, got.open_pos);
			compare_field("close_pos", want.close_pos, got.close_pos);
			compare_field("length", want.length, got.length);
			compare_field("status", want.status, got.status);
			compare_field("final_res", want.fin, got.fin);
			compare_field("pad", want.pad, got.pad);
			if (want.kind == REC_PAIR)
				n_pairs++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_records(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				check_record();
			n_pending = expected_recs.size();
		end
	end

endmodule

// ----- tb/bracket_notation_pair_matcher_tb.sv -----
`timescale 1ns / 1ps
// Top of the bracket pair matcher testbench: clock, reset, string stimulus under three
// pacing phases, watchdog and verdict. Depends on bnpm_pkg and the stream checker.
module bracket_notation_pair_matcher_tb
	import bnpm_pkg::*;
();

	localparam logic [63:0] OPEN_SET    = "(<[{ABCD";
	localparam logic [63:0] CLOSE_SET   = ")>]}abcd";
	localparam int          STALL_LIMIT = 5000;
	localparam int          PHASE_CHARS = 320;
	localparam int          DRAIN_CYCLES = 20;

	typedef enum int {
		PH_SLOW_SINK,
		PH_SLOW_SOURCE,
		PH_FULL_RATE
	} phase_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;
	logic               s_tlast = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [TDATA_W-1:0] m_tdata;
	logic               m_tuser;
	logic               m_tlast;

	int errors;
	int pending;
	int pairs_seen;

	int         tx_idle = 25;
	int         rx_idle = 74;
	int         stall_cycles = 0;
	int         chars_sent = 0;
	int         strings_sent = 0;
	int         phase_chars = 0;
	int         open_cnt [BRACKET_KINDS];
	logic [7:0] str_q[$];

	bracket_notation_pair_matcher uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	bracket_notation_pair_matcher_checker pair_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.errors     (errors),
		.pending    (pending),
		.pairs_seen (pairs_seen)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle);
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog: %0d cycles without a transfer", STALL_LIMIT);
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic logic [7:0] opener_of(input int k);
		return OPEN_SET[8*(7-k) +: 8];
	endfunction

	function automatic logic [7:0] closer_of(input int k);
		return CLOSE_SET[8*(7-k) +: 8];
	endfunction

	task automatic send_sym(input logic [7:0] sym, input logic last);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= sym;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic send_string();
		for (int i = 0; i < str_q.size(); i++)
			send_sym(str_q[i], i == str_q.size() - 1);
		chars_sent   += str_q.size();
		phase_chars  += str_q.size();
		strings_sent++;
		str_q.delete();
	endtask

	task automatic send_text(input string t);
		for (int i = 0; i < t.len(); i++)
			str_q = {str_q, t[i]};
		send_string();
	endtask

	// random structure with interleaved kinds; every opener is closed at the end
	task automatic make_structure(input int n);
		int r;
		int k;
		string plain;
		plain = ".,:-_xZ";
		for (k = 0; k < BRACKET_KINDS; k++)
			open_cnt[k] = 0;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(9);
			k = $urandom_range(BRACKET_KINDS - 1);
			if (r < 4) begin
				str_q = {str_q, opener_of(k)};
				open_cnt[k]++;
			end else if (r < 7 && open_cnt[k] > 0) begin
				str_q = {str_q, closer_of(k)};
				open_cnt[k]--;
			end else begin
				str_q = {str_q, plain[$urandom_range(plain.len() - 1)]};
			end
		end
		for (k = 0; k < BRACKET_KINDS; k++)
			while (open_cnt[k] > 0) begin
				str_q = {str_q, closer_of(k)};
				open_cnt[k]--;
			end
	endtask

	initial begin
		phase_t     ph;
		int         pick;
		int         n;
		logic [7:0] br;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// all kinds nested, unmatched closer, unclosed opener, priority, byte extremes
		send_text("(<[{ABCDdcba}]>)");
		send_text(")");
		send_text("(");
		send_text("a(");
		str_q = {str_q, 8'h00};
		send_string();
		str_q = {str_q, 8'hFF};
		send_string();

		for (int p = 0; p < 3; p++) begin
			ph = phase_t'(p);
			phase_chars = 0;
			case (ph)
				PH_SLOW_SINK: begin
					tx_idle = 25;
					rx_idle = 74;
					// one kind filled to the maximum depth, then dropped characters
					repeat (MAX_LEN) str_q = {str_q, 8'("A")};
					str_q = {str_q, 8'("a")};
					str_q = {str_q, 8'(")")};
					repeat ($urandom_range(4)) str_q = {str_q, 8'($urandom_range(255))};
					send_string();
				end
				PH_SLOW_SOURCE: begin
					tx_idle = 74;
					rx_idle = 25;
				end
				default: begin
					tx_idle = 0;
					rx_idle = 0;
				end
			endcase
			phase_chars = 0;
			while (phase_chars < PHASE_CHARS) begin
				pick = $urandom_range(99);
				if (pick < 60) begin
					make_structure($urandom_range(1, 30));
				end else if (pick < 85) begin
					make_structure($urandom_range(1, 30));
					br = $urandom_range(1) ? opener_of($urandom_range(BRACKET_KINDS - 1))
						: closer_of($urandom_range(BRACKET_KINDS - 1));
					if ($urandom_range(1) && str_q.size() > 1) begin
						n = $urandom_range(1, str_q.size() - 1);
						repeat (n) void'(str_q.pop_back());
					end else begin
						str_q[$urandom_range(str_q.size() - 1)] = br;
					end
				end else begin
					n = $urandom_range(1, 20);
					repeat (n) str_q = {str_q, 8'($urandom_range(255))};
				end
				send_string();
			end
		end

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d characters in %0d strings, %0d pair records checked,", chars_sent,
			strings_sent, pairs_seen);
		$display("with overflow, full depth, full length, errors and three pacing phases.");
		if (errors == 0 && pending == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches, %0d records still expected", errors, pending);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
